@@ src/depth_to_grey_normalizer_core_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the depth to grey normalizer.
// Each macro checks one property on the rising edge of i_clk.
// The check is off while the reset is applied.
// ----------------------------------------------------------------------------
`ifndef DEPTH_TO_GREY_NORMALIZER_CORE_DEFINES_SVH
`define DEPTH_TO_GREY_NORMALIZER_CORE_DEFINES_SVH

// When the antecedent holds, the consequent must hold in the next cycle.
`define DTGN_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define DTGN_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

`endif

@@ src/dtgn_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtgn_pkg
// Shared constants and types for the depth to grey normalizer.
// ----------------------------------------------------------------------------
package dtgn_pkg;

    // Width of one depth sample.
    localparam int DEPTH_BITS = 24;

    // Width of the grey result and the number of divider steps.
    localparam int GREY_BITS = 8;

    // Step counter width for the divider.
    localparam int STEP_BITS = $clog2(GREY_BITS);

    // Reset values of the range trackers.
    localparam logic signed [DEPTH_BITS-1:0] DEPTH_MAXV = {1'b0, {(DEPTH_BITS-1){1'b1}}};
    localparam logic signed [DEPTH_BITS-1:0] DEPTH_MINV = {1'b1, {(DEPTH_BITS-1){1'b0}}};

    // Grey limits.
    localparam logic [GREY_BITS-1:0] GREY_ZERO = '0;
    localparam logic [GREY_BITS-1:0] GREY_FULL = '1;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_CALC,
        ST_DIV,
        ST_FINISH
    } t_state;

    // Divider status seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic last;
    } t_div_stat;

endpackage

@@ src/dtgn_range_tracker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtgn_range_tracker
// Running minimum and maximum of the measure-pass depth samples.
// ----------------------------------------------------------------------------
module dtgn_range_tracker (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_update,
    input  logic                                   i_frame_start,
    input  logic signed [dtgn_pkg::DEPTH_BITS-1:0] i_sample,
    output logic signed [dtgn_pkg::DEPTH_BITS-1:0] o_min,
    output logic signed [dtgn_pkg::DEPTH_BITS-1:0] o_max
);

    logic signed [dtgn_pkg::DEPTH_BITS-1:0] r_min;
    logic signed [dtgn_pkg::DEPTH_BITS-1:0] r_max;
    logic signed [dtgn_pkg::DEPTH_BITS-1:0] n_min;
    logic signed [dtgn_pkg::DEPTH_BITS-1:0] n_max;
    logic signed [dtgn_pkg::DEPTH_BITS-1:0] w_base_min;
    logic signed [dtgn_pkg::DEPTH_BITS-1:0] w_base_max;

    // A frame start reloads the trackers before the sample is folded in.
    always_comb begin
        w_base_min = i_frame_start ? dtgn_pkg::DEPTH_MAXV : r_min;
        w_base_max = i_frame_start ? dtgn_pkg::DEPTH_MINV : r_max;
        n_min      = (i_sample < w_base_min) ? i_sample : w_base_min;
        n_max      = (i_sample > w_base_max) ? i_sample : w_base_max;
    end

    // Tracker registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= dtgn_pkg::DEPTH_MAXV;
            r_max <= dtgn_pkg::DEPTH_MINV;
        end else if (i_update) begin
            r_min <= n_min;
            r_max <= n_max;
        end
    end

    assign o_min = r_min;
    assign o_max = r_max;

endmodule

@@ src/dtgn_divider.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtgn_divider
// Restoring divider that produces one quotient bit per cycle.
// The quotient must fit in GREY_BITS: the top of the dividend is below the
// divisor when a division is started.
// ----------------------------------------------------------------------------
module dtgn_divider (
    input  logic                                                  i_clk,
    input  logic                                                  i_rst_n,
    input  logic                                                  i_start,
    input  logic [dtgn_pkg::DEPTH_BITS+dtgn_pkg::GREY_BITS-1:0]   i_dividend,
    input  logic [dtgn_pkg::DEPTH_BITS-1:0]                       i_divisor,
    output logic [dtgn_pkg::GREY_BITS-1:0]                        o_quotient,
    output dtgn_pkg::t_div_stat                                   o_stat
);

    localparam int DW = dtgn_pkg::DEPTH_BITS;
    localparam int GW = dtgn_pkg::GREY_BITS;

    logic                                 r_busy;
    logic [dtgn_pkg::STEP_BITS-1:0]       r_cnt;
    logic [DW-1:0]                        r_rem;
    logic [GW-1:0]                        r_low;
    logic [GW-1:0]                        r_quo;
    logic [DW-1:0]                        r_div;
    logic [DW:0]                          w_trial;
    logic [DW+1:0]                        w_diff;
    logic                                 w_fits;

    // Shared subtract and compare: one quotient bit per step.
    always_comb begin
        w_trial = {r_rem, r_low[GW-1]};
        w_diff  = {1'b0, w_trial} - {2'b00, r_div};
        w_fits  = !w_diff[DW+1];
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= dtgn_pkg::STEP_BITS'(GW - 1);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[DW+GW-1:GW];
            r_low <= i_dividend[GW-1:0];
            r_div <= i_divisor;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= w_fits ? w_diff[DW-1:0] : w_trial[DW-1:0];
            r_low <= {r_low[GW-2:0], 1'b0};
            r_quo <= {r_quo[GW-2:0], w_fits};
        end
    end

    assign o_quotient  = r_quo;
    assign o_stat.busy = r_busy;
    assign o_stat.last = r_busy && (r_cnt == '0);

endmodule

@@ src/depth_to_grey_normalizer_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_to_grey_normalizer_core
// Two-pass min/max normalization of signed depth samples to 8-bit grey.
// ----------------------------------------------------------------------------
// A measure-pass transaction only updates the running minimum and maximum.
// A convert-pass transaction occupies the block from acceptance through
// PREP and CALC (setup), DIV (the shared restoring divider) and FINISH
// (hand-over of the result); FINISH waits while the output register is full
// and stalled. When the result is known without dividing (flat or empty
// range, sample at or beyond either end of the range) DIV is skipped. The
// output register lets the next transaction be accepted while a result is
// still waiting to be taken.
// ----------------------------------------------------------------------------
module depth_to_grey_normalizer_core (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic signed [dtgn_pkg::DEPTH_BITS-1:0] i_depth_sample,
    input  logic                                   i_convert_pass,
    input  logic                                   i_frame_start,
    input  logic                                   i_frame_end,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic [dtgn_pkg::GREY_BITS-1:0]         o_grey_level,
    output logic                                   o_last_pixel
);

    localparam int DW = dtgn_pkg::DEPTH_BITS;
    localparam int GW = dtgn_pkg::GREY_BITS;

    dtgn_pkg::t_state                 r_state;
    dtgn_pkg::t_state                 n_state;
    dtgn_pkg::t_div_stat              w_div_stat;

    logic                             w_accept;
    logic                             w_track;
    logic                             w_div_start;
    logic                             w_out_free;
    logic                             w_load_out;
    logic signed [DW-1:0]             w_min;
    logic signed [DW-1:0]             w_max;
    logic [GW-1:0]                    w_div_quo;

    logic signed [DW-1:0]             r_sample;
    logic                             r_last;
    logic signed [DW:0]               r_span;
    logic signed [DW:0]               r_num;
    logic                             r_use_fast;
    logic [GW-1:0]                    r_fast_val;

    logic                             w_span_pos;
    logic                             w_num_pos;
    logic                             w_num_ge;
    logic [DW+GW-1:0]                 w_dividend;

    logic                             r_out_valid;
    logic [GW-1:0]                    r_grey;
    logic                             r_out_last;

    // Handshake on the input side.
    assign o_stall  = (r_state != dtgn_pkg::ST_IDLE);
    assign w_accept = i_valid && !o_stall;
    assign w_track  = w_accept && !i_convert_pass;

    // Range trackers.
    dtgn_range_tracker u_tracker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_update      (w_track),
        .i_frame_start (i_frame_start),
        .i_sample      (i_depth_sample),
        .o_min         (w_min),
        .o_max         (w_max)
    );

    // Classification of a convert sample against the measured range.
    always_comb begin
        w_span_pos = !r_span[DW] && (r_span != '0);
        w_num_pos  = !r_num[DW] && (r_num != '0);
        w_num_ge   = (r_num >= r_span);
        w_dividend = {r_num[DW-1:0], {GW{1'b0}}} - {{GW{1'b0}}, r_num[DW-1:0]};
    end

    // Shared divider.
    dtgn_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (r_span[DW-1:0]),
        .o_quotient (w_div_quo),
        .o_stat     (w_div_stat)
    );

    // Output register is free when empty or being emptied.
    assign w_out_free = !r_out_valid || !i_stall;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            dtgn_pkg::ST_IDLE: begin
                if (w_accept && i_convert_pass) begin
                    n_state = dtgn_pkg::ST_PREP;
                end
            end
            dtgn_pkg::ST_PREP: begin
                n_state = dtgn_pkg::ST_CALC;
            end
            dtgn_pkg::ST_CALC: begin
                if (!w_span_pos || !w_num_pos || w_num_ge) begin
                    n_state = dtgn_pkg::ST_FINISH;
                end else begin
                    n_state = dtgn_pkg::ST_DIV;
                end
            end
            dtgn_pkg::ST_DIV: begin
                if (w_div_stat.last) begin
                    n_state = dtgn_pkg::ST_FINISH;
                end
            end
            dtgn_pkg::ST_FINISH: begin
                if (w_out_free) begin
                    n_state = dtgn_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = dtgn_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        w_div_start = 1'b0;
        w_load_out  = 1'b0;
        case (r_state)
            dtgn_pkg::ST_CALC: begin
                w_div_start = w_span_pos && w_num_pos && !w_num_ge;
            end
            dtgn_pkg::ST_FINISH: begin
                w_load_out = w_out_free;
            end
            default: begin
                w_div_start = 1'b0;
                w_load_out  = 1'b0;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dtgn_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Convert sample capture and setup registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sample <= i_depth_sample;
            r_last   <= i_frame_end;
        end
        if (r_state == dtgn_pkg::ST_PREP) begin
            r_span <= {w_max[DW-1], w_max} - {w_min[DW-1], w_min};
            r_num  <= {r_sample[DW-1], r_sample} - {w_min[DW-1], w_min};
        end
        if (r_state == dtgn_pkg::ST_CALC) begin
            r_use_fast <= !w_span_pos || !w_num_pos || w_num_ge;
            r_fast_val <= (w_span_pos && w_num_pos) ? dtgn_pkg::GREY_FULL
                                                    : dtgn_pkg::GREY_ZERO;
        end
    end

    // Output register control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_grey     <= r_use_fast ? r_fast_val : w_div_quo;
            r_out_last <= r_last;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_grey_level = r_grey;
    assign o_last_pixel = r_out_last;

endmodule

@@ src/dtgn_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtgn_checker
// Port-level checks for the depth to grey normalizer, bound to the top level.
// ----------------------------------------------------------------------------
`include "depth_to_grey_normalizer_core_defines.svh"

module dtgn_checker (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    input  logic                                   o_stall,
    input  logic                                   i_convert_pass,
    input  logic                                   o_valid,
    input  logic                                   i_stall,
    input  logic [dtgn_pkg::GREY_BITS-1:0]         o_grey_level,
    input  logic                                   o_last_pixel
);

    // A result that is held back keeps its value.
    `DTGN_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_grey_level) && $stable(o_last_pixel), "stalled result changed")

    // A convert transaction keeps the block busy in the next cycle.
    `DTGN_ASSERT_NEXT(a_convert_busy, i_valid && !o_stall && i_convert_pass, o_stall, "block not busy after a convert transaction")

    // A measure transaction accepted while the output is empty does not fill it.
    `DTGN_ASSERT_NEXT(a_measure_silent, i_valid && !o_stall && !i_convert_pass && !o_valid, !o_valid, "result after a measure transaction")

    // A convert transaction accepted with an empty output does not fill it at once.
    `DTGN_ASSERT_SAME(a_no_early_result, $past(i_valid && !o_stall && i_convert_pass && !o_valid), !o_valid, "result appeared too early")

endmodule

bind depth_to_grey_normalizer_core dtgn_checker u_dtgn_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .i_convert_pass (i_convert_pass),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_grey_level   (o_grey_level),
    .o_last_pixel   (o_last_pixel)
);
